FILE: src/qnlerp_pkg.sv
// Package for the quaternion nlerp unit: shared constants.
`timescale 1ns / 1ps
`default_nettype none
package qnlerp_pkg;
    localparam int LANES = 4;
    localparam logic [63:0] GUESS_BASE = 64'd2505397589;
    localparam logic [63:0] GUESS_SLOPE = 64'd1431655765;
    localparam logic [63:0] THREE_Q30 = 64'd3221225472;
endpackage
`default_nettype wire

FILE: src/quaternion_nlerp_unit.sv
// Top level of the quaternion nlerp unit.
// Takes one beat per cycle while the output is not stalled and returns one result
// beat per input beat, in order. The path runs through the two normalizer pipelines
// (squared length, exponent, first guess, three stages per Newton step, product and
// rounding) around a two-stage blend.
// The whole pipeline advances only when the output register is free or being taken,
// so a stall on the output holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_nlerp_unit #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS = 14,
    parameter int RSQRT_ITERATIONS = 3
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire signed [COMPONENT_WIDTH-1:0] first_x,
    input  wire signed [COMPONENT_WIDTH-1:0] first_y,
    input  wire signed [COMPONENT_WIDTH-1:0] first_z,
    input  wire signed [COMPONENT_WIDTH-1:0] first_w,
    input  wire signed [COMPONENT_WIDTH-1:0] second_x,
    input  wire signed [COMPONENT_WIDTH-1:0] second_y,
    input  wire signed [COMPONENT_WIDTH-1:0] second_z,
    input  wire signed [COMPONENT_WIDTH-1:0] second_w,
    input  wire [14:0]                       blend_weight,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic signed [COMPONENT_WIDTH-1:0] out_x,
    output logic signed [COMPONENT_WIDTH-1:0] out_y,
    output logic signed [COMPONENT_WIDTH-1:0] out_z,
    output logic signed [COMPONENT_WIDTH-1:0] out_w,
    output logic                             degenerate
);
    localparam int SLAT = 3 * RSQRT_ITERATIONS + 5;
    localparam int LAT = 2 * SLAT + 2;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !out_valid || !out_stall;
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    logic signed [COMPONENT_WIDTH-1:0] qa [qnlerp_pkg::LANES];
    logic signed [COMPONENT_WIDTH-1:0] qb [qnlerp_pkg::LANES];
    logic signed [COMPONENT_WIDTH-1:0] na [qnlerp_pkg::LANES];
    logic signed [COMPONENT_WIDTH-1:0] nb [qnlerp_pkg::LANES];
    logic signed [COMPONENT_WIDTH-1:0] res [qnlerp_pkg::LANES];
    logic signed [COMPONENT_WIDTH:0]   mix [qnlerp_pkg::LANES];
    logic nza, nzb, okb, nzr;
    logic [FRACTION_BITS:0] w_sat;
    logic [FRACTION_BITS:0] w_reg [SLAT];
    logic [SLAT-1:0] okp_reg;

    assign qa = '{first_x, first_y, first_z, first_w};
    assign qb = '{second_x, second_y, second_z, second_w};
    assign w_sat = 32'(blend_weight) > (32'd1 << FRACTION_BITS)
                   ? (FRACTION_BITS+1)'(1 << FRACTION_BITS) : (FRACTION_BITS+1)'(blend_weight);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= w_sat;
            for (int k = 1; k < SLAT; k++)
                w_reg[k] <= w_reg[k-1];
            okp_reg <= {okp_reg[SLAT-2:0], okb};
        end
    end

    qnlerp_scale #(.COMPONENT_WIDTH(COMPONENT_WIDTH), .FRACTION_BITS(FRACTION_BITS),
                   .RSQRT_ITERATIONS(RSQRT_ITERATIONS), .IN_W(COMPONENT_WIDTH))
        u_scale_a (.clk(clk), .en(en), .vin(qa), .vout(na), .nonzero(nza));
    qnlerp_scale #(.COMPONENT_WIDTH(COMPONENT_WIDTH), .FRACTION_BITS(FRACTION_BITS),
                   .RSQRT_ITERATIONS(RSQRT_ITERATIONS), .IN_W(COMPONENT_WIDTH))
        u_scale_b (.clk(clk), .en(en), .vin(qb), .vout(nb), .nonzero(nzb));

    qnlerp_blend #(.COMPONENT_WIDTH(COMPONENT_WIDTH), .FRACTION_BITS(FRACTION_BITS))
        u_blend (.clk(clk), .en(en), .na(na), .nb(nb), .weight(w_reg[SLAT-1]),
                 .ok_in(nza && nzb), .mix(mix), .ok_out(okb));

    qnlerp_scale #(.COMPONENT_WIDTH(COMPONENT_WIDTH), .FRACTION_BITS(FRACTION_BITS),
                   .RSQRT_ITERATIONS(RSQRT_ITERATIONS), .IN_W(COMPONENT_WIDTH+1))
        u_scale_r (.clk(clk), .en(en), .vin(mix), .vout(res), .nonzero(nzr));

    logic ok_final;
    assign ok_final = okp_reg[SLAT-1] && nzr;
    assign out_x = ok_final ? res[0] : '0;
    assign out_y = ok_final ? res[1] : '0;
    assign out_z = ok_final ? res[2] : '0;
    assign out_w = ok_final ? res[3] : '0;
    assign degenerate = !ok_final;
endmodule
`default_nettype wire

FILE: src/qnlerp_scale.sv
// Normalization pipeline: squared length, inverse square root and per-lane scaling.
`timescale 1ns / 1ps
`default_nettype none
module qnlerp_scale #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS = 14,
    parameter int RSQRT_ITERATIONS = 3,
    parameter int IN_W = 17
) (
    input  wire                                    clk,
    input  wire                                    en,
    input  wire signed [IN_W-1:0]                  vin [qnlerp_pkg::LANES],
    output logic signed [COMPONENT_WIDTH-1:0]      vout [qnlerp_pkg::LANES],
    output logic                                   nonzero
);
    // Stage 0 sums the squares, stage 1 finds the even exponent and the mantissa,
    // stage 2 forms the first guess and each Newton step takes three stages.
    // Two more stages multiply and round.
    localparam int STAGES = 3 * RSQRT_ITERATIONS + 3;
    localparam logic signed [63:0] HI = (64'sd1 <<< (COMPONENT_WIDTH - 1)) - 64'sd1;

    logic signed [IN_W-1:0] v_reg [STAGES][qnlerp_pkg::LANES];
    logic [63:0]            sum_reg;
    logic [31:0]            m_reg [STAGES];
    logic [31:0]            y_reg [STAGES];
    logic [33:0]            t_reg [STAGES];
    logic [6:0]             e_reg [STAGES];
    logic                   nz_reg [STAGES];
    logic [63:0]            sum_next;
    logic [63:0]            sq_next [qnlerp_pkg::LANES];
    logic                   ovf_next;
    logic [6:0]             p_next;
    logic signed [7:0]      e_next;
    logic [31:0]            m_next;

    always_comb
    begin
        logic [64:0] acc;
        logic [IN_W-1:0] a;
        acc = '0;
        ovf_next = 1'b0;
        for (int i = 0; i < qnlerp_pkg::LANES; i++)
        begin
            a = vin[i][IN_W-1] ? IN_W'(-vin[i]) : IN_W'(vin[i]);
            sq_next[i] = a * a;
            acc = acc + {1'b0, sq_next[i]};
            if (acc[64])
                ovf_next = 1'b1;
        end
        sum_next = ovf_next ? '1 : acc[63:0];
    end

    always_comb
    begin
        p_next = '0;
        for (int b = 0; b < 64; b++)
            if (sum_reg[b])
                p_next = 7'(b);
        e_next = 8'sd31 - $signed({1'b0, p_next});
        if (e_next[0])
            e_next = e_next - 8'sd1;
        m_next = 32'(e_next >= 0 ? sum_reg << e_next : sum_reg >> (-e_next));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [63:0] gp, yy, mt, yd;
            logic [63:0] t;
            sum_reg <= sum_next;
            v_reg[0] <= vin;
            v_reg[1] <= v_reg[0];
            m_reg[1] <= m_next;
            e_reg[1] <= 7'(e_next);
            nz_reg[1] <= (sum_reg != '0);
            for (int k = 2; k < STAGES; k++)
            begin
                v_reg[k] <= v_reg[k-1];
                m_reg[k] <= m_reg[k-1];
                e_reg[k] <= e_reg[k-1];
                nz_reg[k] <= nz_reg[k-1];
            end
            gp = m_reg[1] * qnlerp_pkg::GUESS_SLOPE;
            y_reg[2] <= 32'(qnlerp_pkg::GUESS_BASE - (gp >> 32));
            for (int j = 0; j < RSQRT_ITERATIONS; j++)
            begin
                yy = y_reg[3*j+2] * y_reg[3*j+2];
                t_reg[3*j+3] <= 34'(yy >> 30);
                y_reg[3*j+3] <= y_reg[3*j+2];
                mt = m_reg[3*j+3] * t_reg[3*j+3];
                t = mt >> 32;
                t_reg[3*j+4] <= t >= qnlerp_pkg::THREE_Q30 ? 34'd0
                                                           : 34'(qnlerp_pkg::THREE_Q30 - t);
                y_reg[3*j+4] <= y_reg[3*j+3];
                yd = y_reg[3*j+4] * t_reg[3*j+4];
                y_reg[3*j+5] <= 32'(yd >> 31);
            end
        end
    end

    logic [63:0] prod_reg [qnlerp_pkg::LANES];
    logic        neg_reg [qnlerp_pkg::LANES];
    logic [6:0]  ep_reg;
    logic        nzp_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [IN_W-1:0] a;
            for (int i = 0; i < qnlerp_pkg::LANES; i++)
            begin
                a = v_reg[STAGES-1][i][IN_W-1] ? IN_W'(-v_reg[STAGES-1][i])
                                               : IN_W'(v_reg[STAGES-1][i]);
                prod_reg[i] <= a * y_reg[STAGES-1];
                neg_reg[i] <= v_reg[STAGES-1][i][IN_W-1];
            end
            ep_reg <= e_reg[STAGES-1];
            nzp_reg <= nz_reg[STAGES-1];
        end
    end

    logic signed [COMPONENT_WIDTH-1:0] res_reg [qnlerp_pkg::LANES];
    logic                              nzo_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [63:0] r;
            logic signed [7:0] ee;
            int s;
            ee = $signed({ep_reg[6], ep_reg});
            s = 46 - int'(ee) / 2 - FRACTION_BITS;
            for (int i = 0; i < qnlerp_pkg::LANES; i++)
            begin
                r = (prod_reg[i] + (64'd1 << (s - 1))) >> s;
                if (!nzp_reg)
                    res_reg[i] <= '0;
                else if (neg_reg[i])
                    res_reg[i] <= r > 64'(HI) + 64'd1 ? COMPONENT_WIDTH'(-HI - 1)
                                                      : COMPONENT_WIDTH'(-$signed(r));
                else
                    res_reg[i] <= r > 64'(HI) ? COMPONENT_WIDTH'(HI) : COMPONENT_WIDTH'(r);
            end
            nzo_reg <= nzp_reg;
        end
    end
    assign vout = res_reg;
    assign nonzero = nzo_reg;
endmodule
`default_nettype wire

FILE: src/qnlerp_blend.sv
// Blend stage: dot-product sign, shorter-path flip and per-lane linear mix.
`timescale 1ns / 1ps
`default_nettype none
module qnlerp_blend #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS = 14
) (
    input  wire                               clk,
    input  wire                               en,
    input  wire signed [COMPONENT_WIDTH-1:0]  na [qnlerp_pkg::LANES],
    input  wire signed [COMPONENT_WIDTH-1:0]  nb [qnlerp_pkg::LANES],
    input  wire [FRACTION_BITS:0]             weight,
    input  wire                               ok_in,
    output logic signed [COMPONENT_WIDTH:0]   mix [qnlerp_pkg::LANES],
    output logic                              ok_out
);
    localparam int PW = COMPONENT_WIDTH + FRACTION_BITS + 2;

    logic signed [2*COMPONENT_WIDTH+2:0] prod_reg [qnlerp_pkg::LANES];
    logic signed [PW-1:0]                pa_reg [qnlerp_pkg::LANES];
    logic signed [PW-1:0]                pb_reg [qnlerp_pkg::LANES];
    logic                                ok_reg, ok2_reg;
    logic signed [COMPONENT_WIDTH:0]     mix_reg [qnlerp_pkg::LANES];

    // Both weighted terms are formed beside the dot-product terms, so the second
    // stage just sums the dot, signs the second term, adds and rounds.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [FRACTION_BITS:0] wc;
            wc = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - weight;
            for (int i = 0; i < qnlerp_pkg::LANES; i++)
            begin
                prod_reg[i] <= (2*COMPONENT_WIDTH+3)'(na[i] * nb[i]);
                pa_reg[i] <= PW'(na[i] * $signed({1'b0, wc}));
                pb_reg[i] <= PW'(nb[i] * $signed({1'b0, weight}));
            end
            ok_reg <= ok_in;
        end
    end

    // The merged dot product picks the shorter path for every lane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [2*COMPONENT_WIDTH+4:0] dot;
            logic signed [PW-1:0] bt;
            logic signed [PW:0] acc;
            logic [PW:0] mag;
            dot = '0;
            for (int i = 0; i < qnlerp_pkg::LANES; i++)
                dot = dot + prod_reg[i];
            for (int i = 0; i < qnlerp_pkg::LANES; i++)
            begin
                bt = dot < 0 ? -pb_reg[i] : pb_reg[i];
                acc = pa_reg[i] + bt;
                mag = acc < 0 ? -acc : acc;
                mag = (mag + ((PW+1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
                mix_reg[i] <= (COMPONENT_WIDTH+1)'(acc < 0 ? -mag : mag);
            end
            ok2_reg <= ok_reg;
        end
    end
    assign mix = mix_reg;
    assign ok_out = ok2_reg;
endmodule
`default_nettype wire

FILE: src/qnlerp_checker.sv
// Port-level checker for the quaternion nlerp unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module qnlerp_checker #(
    parameter int COMPONENT_WIDTH = 16
) (
    input wire clk,
    input wire rst_n,
    input wire in_stall,
    input wire out_valid,
    input wire out_stall,
    input wire signed [COMPONENT_WIDTH-1:0] out_x,
    input wire degenerate
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x))
        else $error("result beat changed under stall");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> out_x == 0)
        else $error("degenerate beat carries data");
endmodule

bind quaternion_nlerp_unit qnlerp_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .out_x(out_x), .degenerate(degenerate));
`default_nettype wire
